// ===== hw/rtl/sliding_window_median_top_defines.svh =====
// ----------------------------------------------------------------------------
// sliding window median - assertion macros
// shared property shapes for the checker of the median filter
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types of the sliding window median filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 32;

   // window size register
   localparam int                 WSIZE_W     = 7;
   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

   // register port
   localparam int         CSR_DATA_W      = 32;
   localparam int         CSR_ADDR_W      = 3;
   localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

   // what each cell tells its neighbours
   typedef struct packed {
      logic keep;   // holds a sample that survives this request
      logic le;     // stored sample <= incoming sample
      logic ev;     // holds the oldest sample, dropped this request
   } cell_stat_type;

   // broadcast to every cell
   typedef struct packed {
      logic load;
      logic full;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: holds a sample and its age and picks its
// next content from itself, a neighbour or the incoming sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int AGE_W        = 6,
   parameter int CNT_W        = 7,
   parameter int IDX          = 0
) (
   input  logic                           clock,
   input  cell_ctl_type                   ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] key,
   input  logic        [CNT_W-1:0]        fill,
   input  logic        [AGE_W-1:0]        evict_age,
   input  logic        [AGE_W-1:0]        mid_idx,
   input  logic                           eb,
   input  cell_stat_type                  stat_l,
   input  cell_stat_type                  stat_r,
   input  logic signed [SAMPLE_WIDTH-1:0] value_l,
   input  logic signed [SAMPLE_WIDTH-1:0] value_r,
   input  logic        [AGE_W-1:0]        age_l,
   input  logic        [AGE_W-1:0]        age_r,
   output cell_stat_type                  stat,
   output logic signed [SAMPLE_WIDTH-1:0] value,
   output logic        [AGE_W-1:0]        age,
   output logic        [SAMPLE_WIDTH-1:0] tap
);

   logic signed [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic        [AGE_W-1:0]        age_ff, age_in;
   logic                           valid, ev, keep, le;
   logic                           eb_l, eb_r;
   logic                           take_l, take_s, take_r;

   assign valid = (fill > CNT_W'(IDX));
   assign ev    = valid && ctl.full && (age_ff == evict_age);
   assign keep  = valid && !ev;
   assign le    = (value_ff <= key);

   assign stat  = '{keep: keep, le: le, ev: ev};
   assign value = value_ff;
   assign age   = age_ff;

   // hole left of each neighbour, from our own flag
   assign eb_l = eb && !stat_l.ev;
   assign eb_r = eb || ev;

   // survivors left of the new sample slide down over the hole,
   // survivors right of it slide up to make room
   assign take_r = stat_r.keep && stat_r.le && eb_r;
   assign take_s = keep && (le != eb);
   assign take_l = stat_l.keep && !stat_l.le && !eb_l;

   always_comb begin
      value_in = key;
      age_in   = '0;
      if (take_r) begin
         value_in = value_r;
         age_in   = age_r + AGE_W'(1);
      end else if (take_s) begin
         value_in = value_ff;
         age_in   = age_ff + AGE_W'(1);
      end else if (take_l) begin
         value_in = value_l;
         age_in   = age_l + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign tap = (mid_idx == AGE_W'(IDX)) ? value_ff : '0;

endmodule

// ===== hw/rtl/sliding_window_median_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_top
// running median over the last window_size samples, kept sorted in a row
// of cells that drop the oldest and insert the newest in one step
// ----------------------------------------------------------------------------
// usage:
//  - req_ carries one signed sample per request, rsp_ one median per result
//  - a request is taken at an edge with req_valid and req_ready high; the row of
//    cells drops the oldest and inserts the new sample at that edge, so one
//    request per cycle is taken while req_ready is high; rsp_valid follows through
//    pend_ff, then rsp_valid_ff; the median is the lower median for an even window
//  - no result until window_size samples have been seen after reset or a
//    window_size write; from then on every request gives one result
//  - window_size of zero acts as one, values above WINDOW_MAX saturate
//  - a stalled result holds in the output register; one further median may
//    wait behind it, after that req_ready drops until rsp_ready returns
//  - reset sets window_size to 3 and empties the window, no clearing pass
//  - unenforced: the user writes window_size over the register port only while idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_median_top import swm_pkg::*; #(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic        [CSR_ADDR_W-1:0]   paddr,
   input  logic        [CSR_DATA_W-1:0]   pwdata,
   output logic        [CSR_DATA_W-1:0]   prdata,
   output logic                           pready
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int EXT_W = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

   logic        [WSIZE_W-1:0]      wsize_ff, wsize_in;
   logic        [CNT_W-1:0]        fill_ff, fill_in;
   logic                           pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_median_ff;

   logic        [EXT_W-1:0]        wsize_ext;
   logic        [CNT_W-1:0]        eff;
   logic        [AGE_W-1:0]        mid_idx, evict_age;
   logic                           full, result, fire, rsp_free, csr_write, reg_hit;
   cell_ctl_type                   ctl;

   logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
   logic        [AGE_W-1:0]        cell_age   [WINDOW_MAX];
   cell_stat_type                  cell_stat  [WINDOW_MAX];
   logic        [SAMPLE_WIDTH-1:0] cell_tap   [WINDOW_MAX];
   logic        [WINDOW_MAX-1:0]   ev_vec, eb_vec;
   logic        [SAMPLE_WIDTH-1:0] tap_or;

   // effective window size and the sorted slot of the median
   assign wsize_ext = EXT_W'(wsize_ff);
   always_comb begin
      if (wsize_ext == '0) begin
         eff = CNT_W'(1);
      end else if (wsize_ext > EXT_W'(WINDOW_MAX)) begin
         eff = CNT_W'(WINDOW_MAX);
      end else begin
         eff = CNT_W'(wsize_ext);
      end
   end

   assign evict_age = AGE_W'(eff - CNT_W'(1));
   assign mid_idx   = AGE_W'((eff - CNT_W'(1)) >> 1);

   assign full   = (fill_ff == eff);
   assign result = full || (CNT_W'(fill_ff + CNT_W'(1)) == eff);

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && (!pend_ff || rsp_free);
   assign fire      = req_valid && req_ready;

   assign csr_write = psel && penable && pwrite && pready;
   assign reg_hit   = (paddr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE);
   assign pready    = 1'b1;
   assign prdata    = reg_hit ? CSR_DATA_W'(wsize_ff) : '0;

   assign ctl = '{load: fire, full: full};

   // row of cells
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      cell_stat_type                  stat_l, stat_r;
      logic signed [SAMPLE_WIDTH-1:0] value_l, value_r;
      logic        [AGE_W-1:0]        age_l, age_r;

      if (i == 0) begin : g_first
         assign stat_l    = '0;
         assign value_l   = '0;
         assign age_l     = '0;
         assign eb_vec[i] = 1'b0;
      end else begin : g_mid
         assign stat_l    = cell_stat[i-1];
         assign value_l   = cell_value[i-1];
         assign age_l     = cell_age[i-1];
         assign eb_vec[i] = |ev_vec[i-1:0];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign stat_r  = '0;
         assign value_r = '0;
         assign age_r   = '0;
      end else begin : g_next
         assign stat_r  = cell_stat[i+1];
         assign value_r = cell_value[i+1];
         assign age_r   = cell_age[i+1];
      end

      assign ev_vec[i] = cell_stat[i].ev;

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .AGE_W        (AGE_W),
         .CNT_W        (CNT_W),
         .IDX          (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .key       (req_sample),
         .fill      (fill_ff),
         .evict_age (evict_age),
         .mid_idx   (mid_idx),
         .eb        (eb_vec[i]),
         .stat_l    (stat_l),
         .stat_r    (stat_r),
         .value_l   (value_l),
         .value_r   (value_r),
         .age_l     (age_l),
         .age_r     (age_r),
         .stat      (cell_stat[i]),
         .value     (cell_value[i]),
         .age       (cell_age[i]),
         .tap       (cell_tap[i])
      );
   end

   // only the median slot drives its tap
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         tap_or = tap_or | cell_tap[i];
      end
   end

   always_comb begin
      wsize_in = wsize_ff;
      fill_in  = fill_ff;
      if (csr_write && reg_hit) begin
         wsize_in = pwdata[WSIZE_W-1:0];
         fill_in  = '0;
      end else if (fire && !full) begin
         fill_in = CNT_W'(fill_ff + CNT_W'(1));
      end
   end

   always_comb begin
      if (fire) begin
         pend_in = result;
      end else begin
         pend_in = pend_ff && !rsp_free;
      end

      if (pend_ff && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff     <= WSIZE_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wsize_ff     <= wsize_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff && rsp_free) begin
         rsp_median_ff <= tap_or;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

// ===== hw/rtl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// port-level checks of the sliding window median filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_median_top_defines.svh"

module swm_checker import swm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_median,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic        [CSR_ADDR_W-1:0]   paddr,
   input logic        [CSR_DATA_W-1:0]   pwdata,
   input logic        [CSR_DATA_W-1:0]   prdata,
   input logic                           pready
);

   logic                           rsp_stall, req_take, wsize_sel, wsize_write;
   logic                           rsp_kept, readback_ok;
   logic                           take_ff, take_2_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_median_ff;
   logic        [WSIZE_W-1:0]      wsize_wr_ff;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_take    = req_valid && req_ready;
   assign wsize_sel   = (paddr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE);
   assign wsize_write = psel && penable && pwrite && pready && wsize_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff   <= 1'b0;
         take_2_ff <= 1'b0;
      end else begin
         take_ff   <= req_take;
         take_2_ff <= take_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median;
      wsize_wr_ff   <= pwdata[WSIZE_W-1:0];
   end

   assign rsp_kept    = rsp_valid && (rsp_median == rsp_median_ff);
   assign readback_ok = !wsize_sel || (prdata[WSIZE_W-1:0] == wsize_wr_ff);

   // a stalled median stays put
   `SWM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_kept, "stalled median moved")

   // a fresh result always follows a taken request, as delayed through take_2_ff
   `SWM_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid), take_2_ff, "orphan result")

   // requests are held off only behind a stalled result
   `SWM_ASSERT_IMP(a_req_stall, clock, reset, !req_ready, rsp_stall, "refused with output free")

   // the window size reads back as written
   `SWM_ASSERT_NXT(a_wsize_rb, clock, reset, wsize_write, readback_ok, "readback mismatch")

endmodule

bind sliding_window_median_top swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (.*);
